>>> hdl/rectangle_raster_canvas_macros.svh
// rectangle_raster_canvas_macros.svh
// Assertion helpers for the rectangle raster canvas; no dependencies.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef RECTANGLE_RASTER_CANVAS_MACROS_SVH
`define RECTANGLE_RASTER_CANVAS_MACROS_SVH

// same-cycle implication, muted while reset is held
`define RRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted while reset is held
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rrc_pkg.sv
// rrc_pkg.sv
// Constants, codes and types of the rectangle raster canvas.
// No dependencies.
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int MAX_SIDE  = 256;
    localparam int SIDE_W    = 8;               // bits of a row or column index
    localparam int CFG_SIDE_W = 9;              // width/height register width
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 26;              // 24-bit edge + 24-bit size + one, signed
    localparam int ADDR_W    = 2 * SIDE_W;

    localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_BITS;

    localparam logic [CFG_SIDE_W-1:0] SIDE_MAX = CFG_SIDE_W'(MAX_SIDE);

    // rectangle kinds (character codes)
    localparam logic [7:0] KIND_FILLED  = 8'd82;
    localparam logic [7:0] KIND_OUTLINE = 8'd114;

    // item modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_DRAW  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

>>> hdl/rectangle_raster_canvas.sv
// rectangle_raster_canvas.sv
// Top level: 256x256 character canvas in one RAM, clear/draw sweeper, cell reader.
// Depends on rrc_pkg and rectangle_raster_canvas_macros.svh.
// Usage:
//  - Slave channel (i_s_*): one word per command. tuser = {rect_kind, mode},
//    mode selects clear (0), draw rectangle (1) or read one cell (2).
//  - Master channel (o_m_*): one word per command. tuser = status
//    (1 = rectangle rejected), tdata = cell_char (read only, else 0).
//  - Config channel (i_cfg_*): always ready; index 0 width, 1 height,
//    2 background char. Write only while no command is in flight.
//  - Sequencing: clear and accepted draw sweep the width*height cells in use
//    (one canvas cell visited per cycle through the single RAM write port),
//    then pass to the done state; a read passes through the read state, as the
//    RAM read is registered; rejected draws and mode 3 go straight to done.
//  - One command in flight at a time. The finished result sits in the
//    output register, so the next command is taken while it waits.
//  - If the receiver stalls with a result still pending, the following
//    result holds in the done state until the output register frees.
//  - Reset clears control state and config to 256x256, background 0x20.
//    Canvas contents are undefined after reset; clear before reading.
`timescale 1ns / 1ps
`include "rectangle_raster_canvas_macros.svh"

module rectangle_raster_canvas (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata, low to high: left_edge[24] top_edge[24] rect_width[24]
    //   rect_height[24] brush_char[8] read_col[8] read_row[8]
    input  logic [119:0] i_s_tdata,
    // tuser, low to high: mode[2] rect_kind[8]
    input  logic [9:0]   i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: cell_char[8]
    output logic [7:0]   o_m_tdata,
    // tuser: status[1]
    output logic         o_m_tuser,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [8:0]   i_cfg_data
);

    localparam int CW = rrc_pkg::COORD_W;
    localparam int SW = rrc_pkg::SIDE_W;

    // ---------------- unpacked command fields ----------------
    logic [1:0]          w_mode;
    logic [7:0]          w_kind;
    logic signed [23:0]  w_left, w_top, w_rwidth, w_rheight;
    logic [7:0]          w_brush;
    logic [SW-1:0]       w_rcol, w_rrow;

    assign w_mode    = i_s_tuser[1:0];
    assign w_kind    = i_s_tuser[9:2];
    assign w_left    = i_s_tdata[23:0];
    assign w_top     = i_s_tdata[47:24];
    assign w_rwidth  = i_s_tdata[71:48];
    assign w_rheight = i_s_tdata[95:72];
    assign w_brush   = i_s_tdata[103:96];
    assign w_rcol    = i_s_tdata[111:104];
    assign w_rrow    = i_s_tdata[119:112];

    // ---------------- configuration ----------------
    logic [rrc_pkg::CFG_SIDE_W-1:0] r_cfg_width, r_cfg_height;
    logic [7:0]                     r_cfg_bg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= rrc_pkg::SIDE_MAX;
            r_cfg_height <= rrc_pkg::SIDE_MAX;
            r_cfg_bg     <= 8'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rrc_pkg::CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                rrc_pkg::CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                rrc_pkg::CFG_BG:     r_cfg_bg     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sides in use, saturated to 1..MAX_SIDE, as last index
    logic [rrc_pkg::CFG_SIDE_W-1:0] w_cols, w_rows;
    logic [SW-1:0]                  w_last_col, w_last_row;

    always_comb begin
        w_cols = r_cfg_width;
        if (r_cfg_width == '0)
            w_cols = rrc_pkg::CFG_SIDE_W'(1);
        else if (r_cfg_width > rrc_pkg::SIDE_MAX)
            w_cols = rrc_pkg::SIDE_MAX;
        w_rows = r_cfg_height;
        if (r_cfg_height == '0)
            w_rows = rrc_pkg::CFG_SIDE_W'(1);
        else if (r_cfg_height > rrc_pkg::SIDE_MAX)
            w_rows = rrc_pkg::SIDE_MAX;
    end

    assign w_last_col = SW'(w_cols - rrc_pkg::CFG_SIDE_W'(1));
    assign w_last_row = SW'(w_rows - rrc_pkg::CFG_SIDE_W'(1));

    // ---------------- command decode ----------------
    logic w_accept;
    logic w_kind_ok, w_size_ok, w_draw_ok, w_read_in;

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_kind_ok = (w_kind == rrc_pkg::KIND_FILLED) || (w_kind == rrc_pkg::KIND_OUTLINE);
    assign w_size_ok = !w_rwidth[23] && (w_rwidth != '0) &&
                       !w_rheight[23] && (w_rheight != '0);
    assign w_draw_ok = w_kind_ok && w_size_ok;
    assign w_read_in = ({1'b0, w_rcol} < w_cols) && ({1'b0, w_rrow} < w_rows);

    // rectangle bounds, extended to the coordinate width
    logic signed [CW-1:0] w_lx, w_ly, w_rx, w_ry;

    assign w_lx = CW'(w_left);
    assign w_ly = CW'(w_top);
    assign w_rx = w_lx + CW'(w_rwidth);
    assign w_ry = w_ly + CW'(w_rheight);

    // ---------------- state machine ----------------
    rrc_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_col, r_row, r_last_col, r_last_row;
    logic          r_clear, r_filled;
    logic [7:0]    r_brush;
    logic signed [CW-1:0] r_lx, r_ly, r_rx, r_ry;   // covered bounds
    logic signed [CW-1:0] r_lx1, r_ly1, r_rxm, r_rym; // outline band limits
    logic          r_res_status;
    logic [7:0]    r_res_cell;
    logic [7:0]    r_rd_data;

    logic w_sweep_end, w_out_load, w_we, w_cov;

    assign w_sweep_end = (r_col == r_last_col) && (r_row == r_last_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= rrc_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            rrc_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (w_mode == rrc_pkg::MODE_CLEAR ||
                        (w_mode == rrc_pkg::MODE_DRAW && w_draw_ok))
                        n_state = rrc_pkg::ST_SWEEP;
                    else if (w_mode == rrc_pkg::MODE_READ && w_read_in)
                        n_state = rrc_pkg::ST_READ;
                    else
                        n_state = rrc_pkg::ST_DONE;
                end
            end
            rrc_pkg::ST_SWEEP: begin
                if (w_sweep_end)
                    n_state = rrc_pkg::ST_DONE;
            end
            rrc_pkg::ST_READ: begin
                n_state = rrc_pkg::ST_DONE;
            end
            rrc_pkg::ST_DONE: begin
                if (!o_m_tvalid || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = rrc_pkg::ST_IDLE;
                end
            end
            default: n_state = rrc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sweep coverage ----------------
    // pixel point: index scaled to fixed point, always non-negative
    logic signed [CW-1:0] w_px, w_py;

    assign w_px = CW'({r_col, {rrc_pkg::FRAC_BITS{1'b0}}});
    assign w_py = CW'({r_row, {rrc_pkg::FRAC_BITS{1'b0}}});

    // inside the bounds, and for an outline also within one unit of any edge
    assign w_cov = (w_px >= r_lx) && (w_px <= r_rx) &&
                   (w_py >= r_ly) && (w_py <= r_ry) &&
                   (r_filled || (w_px < r_lx1) || (w_px > r_rxm) ||
                    (w_py < r_ly1) || (w_py > r_rym));

    assign w_we = (r_state == rrc_pkg::ST_SWEEP) && (r_clear || w_cov);

    // ---------------- command and sweep registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == rrc_pkg::ST_SWEEP) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + SW'(1);
            end else begin
                r_col <= r_col + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_clear      <= (w_mode == rrc_pkg::MODE_CLEAR);
            r_filled     <= (w_kind == rrc_pkg::KIND_FILLED);
            r_brush      <= w_brush;
            r_last_col   <= w_last_col;
            r_last_row   <= w_last_row;
            r_lx         <= w_lx;
            r_ly         <= w_ly;
            r_rx         <= w_rx;
            r_ry         <= w_ry;
            r_lx1        <= w_lx + rrc_pkg::COORD_ONE;
            r_ly1        <= w_ly + rrc_pkg::COORD_ONE;
            r_rxm        <= w_rx - rrc_pkg::COORD_ONE;
            r_rym        <= w_ry - rrc_pkg::COORD_ONE;
            r_res_status <= (w_mode == rrc_pkg::MODE_DRAW && !w_draw_ok) ?
                            rrc_pkg::STATUS_REJECTED : rrc_pkg::STATUS_OK;
            r_res_cell   <= 8'd0;
        end else if (r_state == rrc_pkg::ST_READ) begin
            r_res_cell   <= r_rd_data;
        end
    end

    // ---------------- canvas RAM ----------------
    // Writes land only during a sweep. The read port samples every cycle, but
    // only the word read at accept in idle is kept, so it never meets a pending write.
    logic [7:0] r_mem [0:(rrc_pkg::MAX_SIDE * rrc_pkg::MAX_SIDE)-1];

    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[{r_row, r_col}] <= r_clear ? r_cfg_bg : r_brush;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[{w_rrow, w_rcol}];
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_m_tvalid <= 1'b0;
        else if (w_out_load)
            o_m_tvalid <= 1'b1;
        else if (i_m_tready)
            o_m_tvalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_m_tdata <= r_res_cell;
            o_m_tuser <= r_res_status;
        end
    end

    // ---------------- assertions ----------------
    `RRC_ASSERT_NEXT(a_accept_leaves_idle, w_accept,
        r_state != rrc_pkg::ST_IDLE, "accepted word did not start work")
    `RRC_ASSERT_NOW(a_sweep_in_bounds, r_state == rrc_pkg::ST_SWEEP,
        (r_col <= r_last_col) && (r_row <= r_last_row), "sweep outside canvas")
    `RRC_ASSERT_NOW(a_result_from_done, o_m_tvalid && !$past(o_m_tvalid),
        $past(r_state == rrc_pkg::ST_DONE), "result appeared outside done state")
    `RRC_ASSERT_NOW(a_write_only_sweep, w_we,
        !o_s_tready, "canvas written while taking commands")

endmodule

>>> tb/rectangle_raster_canvas_test.sv
// rectangle_raster_canvas_test.sv
// Self-checking bench for the rectangle raster canvas: clear, draw and read words.
// Depends on rrc_pkg and the rectangle_raster_canvas top level.
`timescale 1ns / 1ps

module rectangle_raster_canvas_test;

    // mode 3 has no name in the package: the block takes it and does nothing
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 2000;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // one command word, fields as the block sees them
    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         kind;
        logic signed [23:0] left;
        logic signed [23:0] top;
        logic signed [23:0] wid;
        logic signed [23:0] hgt;
        logic [7:0]         brush;
        logic [7:0]         col;
        logic [7:0]         row;
    } t_canvas_cmd;

    typedef struct packed {
        logic       status;
        logic [7:0] cell_char;
    } t_canvas_reply;

    // DUT ports; the bench's drives are all known from time zero
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [119:0] i_s_tdata = '0;
    logic [9:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [7:0]   o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [8:0]   i_cfg_data = '0;

    // shadow of the block: registers as written, plus the whole canvas
    logic [8:0] side_w_reg = 9'd256;
    logic [8:0] side_h_reg = 9'd256;
    logic [7:0] bg_reg = 8'd32;
    logic [7:0] canvas_model [0:rrc_pkg::MAX_SIDE*rrc_pkg::MAX_SIDE-1];

    t_canvas_cmd   cmd_backlog[$];     // words waiting to go out
    t_canvas_reply pending_replies[$]; // predicted replies, oldest first
    t_canvas_cmd   cmd_on_bus;

    t_idle_mode  idle_mode = IDLE_NONE;
    logic        pressure_req = 1'b0;
    logic        pressure_taken = 1'b0;
    int          hold_left = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    rectangle_raster_canvas i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the shadow canvas, returns the reply
    // ------------------------------------------------------------------
    function automatic t_canvas_reply rasterize_command(t_canvas_cmd c);
        t_canvas_reply r;
        int     cw, ch, x, y;
        longint lx, ly, w, h, px, py;
        longint one;
        logic   hit;
        r.status = rrc_pkg::STATUS_OK;
        r.cell_char = 8'd0;
        one = longint'(1) << rrc_pkg::FRAC_BITS;
        // size registers are used saturated to 1..MAX_SIDE
        cw = (side_w_reg == 0) ? 1 :
             (side_w_reg > rrc_pkg::MAX_SIDE) ? rrc_pkg::MAX_SIDE : int'(side_w_reg);
        ch = (side_h_reg == 0) ? 1 :
             (side_h_reg > rrc_pkg::MAX_SIDE) ? rrc_pkg::MAX_SIDE : int'(side_h_reg);
        lx = $signed(c.left);
        ly = $signed(c.top);
        w = $signed(c.wid);
        h = $signed(c.hgt);
        case (c.mode)
            rrc_pkg::MODE_CLEAR: begin
                for (y = 0; y < ch; y++)
                    for (x = 0; x < cw; x++)
                        canvas_model[y * rrc_pkg::MAX_SIDE + x] = bg_reg;
            end
            rrc_pkg::MODE_DRAW: begin
                if (w <= 0 || h <= 0 || (c.kind != rrc_pkg::KIND_FILLED &&
                                         c.kind != rrc_pkg::KIND_OUTLINE)) begin
                    // rejected: canvas untouched
                    r.status = rrc_pkg::STATUS_REJECTED;
                end else begin
                    for (y = 0; y < ch; y++) begin
                        py = longint'(y) << rrc_pkg::FRAC_BITS;
                        for (x = 0; x < cw; x++) begin
                            px = longint'(x) << rrc_pkg::FRAC_BITS;
                            hit = px >= lx && px <= lx + w && py >= ly && py <= ly + h;
                            // outline keeps only points within one unit of a side
                            if (hit && c.kind == rrc_pkg::KIND_OUTLINE)
                                hit = (px - lx < one) || (lx + w - px < one) ||
                                      (py - ly < one) || (ly + h - py < one);
                            if (hit)
                                canvas_model[y * rrc_pkg::MAX_SIDE + x] = c.brush;
                        end
                    end
                end
            end
            rrc_pkg::MODE_READ: begin
                if (int'(c.col) < cw && int'(c.row) < ch)
                    r.cell_char = canvas_model[int'(c.row) * rrc_pkg::MAX_SIDE + int'(c.col)];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command builders; unused fields carry random bits
    // ------------------------------------------------------------------
    function automatic t_canvas_cmd blank_cmd(logic [1:0] m);
        t_canvas_cmd c;
        c.mode = m;
        c.kind = 8'($urandom);
        c.left = 24'($urandom);
        c.top = 24'($urandom);
        c.wid = 24'($urandom);
        c.hgt = 24'($urandom);
        c.brush = 8'($urandom);
        c.col = 8'($urandom);
        c.row = 8'($urandom);
        return c;
    endfunction

    function automatic t_canvas_cmd read_cmd(int x, int y);
        t_canvas_cmd c;
        c = blank_cmd(rrc_pkg::MODE_READ);
        c.col = 8'(x);
        c.row = 8'(y);
        return c;
    endfunction

    function automatic t_canvas_cmd draw_cmd(logic [7:0] k, int l, int t, int w, int h,
                                             logic [7:0] b);
        t_canvas_cmd c;
        c = blank_cmd(rrc_pkg::MODE_DRAW);
        c.kind = k;
        c.left = 24'(l);
        c.top = 24'(t);
        c.wid = 24'(w);
        c.hgt = 24'(h);
        c.brush = b;
        return c;
    endfunction

    // random word for a canvas of cw x ch cells in use
    function automatic t_canvas_cmd random_command(int cw, int ch);
        t_canvas_cmd c;
        int pick, sub, l, t, w, h;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        if (pick < 10) begin
            c = blank_cmd(rrc_pkg::MODE_CLEAR);
        end else if (pick < 15) begin
            c = blank_cmd(MODE_NONE);
        end else if (pick < 50) begin
            c = blank_cmd(rrc_pkg::MODE_READ);
            if (sub < 85) begin
                c.col = 8'($urandom_range(0, cw - 1));
                c.row = 8'($urandom_range(0, ch - 1));
            end
        end else begin
            c = blank_cmd(rrc_pkg::MODE_DRAW);
            if (sub < 85) begin
                // well-formed rectangle around the canvas in use
                l = int'($urandom_range(0, (cw + 4) * 256)) - 512;
                t = int'($urandom_range(0, (ch + 4) * 256)) - 512;
                w = $urandom_range(1, (cw + 2) * 256);
                h = $urandom_range(1, (ch + 2) * 256);
                if ($urandom_range(0, 1) == 0) begin
                    // whole-unit corners land exactly on cell centers
                    l = l & ~255;
                    t = t & ~255;
                    w = (w & ~255) == 0 ? 256 : (w & ~255);
                    h = (h & ~255) == 0 ? 256 : (h & ~255);
                end
                c.kind = ($urandom_range(0, 1) == 0) ? rrc_pkg::KIND_FILLED :
                                                       rrc_pkg::KIND_OUTLINE;
                c.left = 24'(l);
                c.top = 24'(t);
                c.wid = 24'(w);
                c.hgt = 24'(h);
            end else begin
                case (sub % 4)
                    0: c.wid = 24'(-int'($urandom_range(0, 8388608)));
                    1: c.hgt = 24'd0;
                    2: begin
                        c.wid = 24'($urandom_range(1, 8388607));
                        c.hgt = 24'($urandom_range(1, 8388607));
                    end
                    default: ; // fully random word
                endcase
            end
        end
        return c;
    endfunction

    function automatic logic sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 65;
            IDLE_BOTH:   return $urandom_range(0, 99) < 11;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_gap();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 65;
            IDLE_BOTH:     return $urandom_range(0, 99) < 11;
            default:       return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command driver: predicts on acceptance, then offers the next word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                pending_replies.push_back(rasterize_command(cmd_on_bus));
            if (!i_s_tvalid || o_s_tready) begin
                if (cmd_backlog.size() != 0 && !sender_gap()) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    i_s_tdata <= {cmd_on_bus.row, cmd_on_bus.col, cmd_on_bus.brush,
                                  cmd_on_bus.hgt, cmd_on_bus.wid, cmd_on_bus.top,
                                  cmd_on_bus.left};
                    i_s_tuser <= {cmd_on_bus.kind, cmd_on_bus.mode};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, armed once; the sender keeps offering meanwhile
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_req && !pressure_taken) begin
            hold_left <= HOLD_CYCLES;
            pressure_taken <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= (hold_left == 0) && !receiver_gap();
    end

    // ------------------------------------------------------------------
    // Reply monitor: each word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_canvas_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_replies.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("%0t: reply with nothing pending: status %0d cell %0d",
                             $realtime, o_m_tuser, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_m_tuser !== want.status || o_m_tdata !== want.cell_char) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: reply mismatch: status %0d/%0d cell %0d/%0d (exp/act)",
                                 $realtime, want.status, o_m_tuser, want.cell_char,
                                 o_m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rrc_pkg::CFG_WIDTH:  side_w_reg = val;
            rrc_pkg::CFG_HEIGHT: side_h_reg = val;
            rrc_pkg::CFG_BG:     bg_reg = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_canvas(logic [8:0] w, logic [8:0] h, logic [7:0] bg);
        write_reg(rrc_pkg::CFG_WIDTH, w);
        write_reg(rrc_pkg::CFG_HEIGHT, h);
        write_reg(rrc_pkg::CFG_BG, {1'b0, bg});
    endtask

    // every command gives exactly one reply, so an empty prediction queue
    // means the block is idle again; a few cycles of margin on top
    task automatic drain_backlog();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_s_tvalid || pending_replies.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_idle_mode phase_idle [4];
        int p, n, cw, ch;
        logic [8:0] w, h;
        phase_idle = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, full 256x256: the first clear writes every cell,
        // so no later read can touch a never-written one
        @(negedge i_clk);
        cmd_backlog.push_back(blank_cmd(rrc_pkg::MODE_CLEAR));
        cmd_backlog.push_back(read_cmd(0, 0));
        cmd_backlog.push_back(read_cmd(255, 255));
        // outline clipped by the far corner, half-unit left side
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_OUTLINE, 250 * 256 + 128, 250 * 256,
                                       10 * 256, 3 * 256, 8'h23));
        cmd_backlog.push_back(read_cmd(255, 250));
        cmd_backlog.push_back(read_cmd(252, 251));
        drain_backlog();

        // small canvas, the field extremes and the rejections
        set_canvas(9'd8, 9'd6, 8'h2e);
        @(negedge i_clk);
        cmd_backlog.push_back(blank_cmd(rrc_pkg::MODE_CLEAR));
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_FILLED, -8388608, -8388608,
                                       8388607, 8388607, 8'h41));
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_FILLED, 0, 0, 8388607, 8388607,
                                       8'hff));
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_OUTLINE, 384, 256, 768, 512, 8'h6f));
        // sides thinner than a unit: every covered point is outline
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_OUTLINE, 1024, 256, 128, 1024, 8'h00));
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_FILLED, 0, 0, 0, 512, 8'h58));
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_FILLED, 0, 0, 512, -8388608, 8'h58));
        cmd_backlog.push_back(draw_cmd(8'hff, 0, 0, 512, 512, 8'h58));
        cmd_backlog.push_back(draw_cmd(8'h00, 0, 0, 512, 512, 8'h58));
        cmd_backlog.push_back('{MODE_NONE, 8'hff, 24'hffffff, 24'hffffff, 24'hffffff,
                                24'hffffff, 8'hff, 8'hff, 8'hff});
        cmd_backlog.push_back(read_cmd(7, 5));
        cmd_backlog.push_back(read_cmd(8, 0));
        cmd_backlog.push_back(read_cmd(0, 6));
        drain_backlog();

        // out-of-range sizes saturate: 511 -> 256 columns, 0 -> 1 row
        set_canvas(9'd511, 9'd0, 8'hff);
        @(negedge i_clk);
        cmd_backlog.push_back(blank_cmd(rrc_pkg::MODE_CLEAR));
        cmd_backlog.push_back(draw_cmd(rrc_pkg::KIND_OUTLINE, 200 * 256, -256, 100 * 256,
                                       256, 8'h78));
        cmd_backlog.push_back(read_cmd(255, 0));
        cmd_backlog.push_back(read_cmd(0, 1));
        drain_backlog();

        // one column, full height
        set_canvas(9'd1, 9'd256, 8'h00);
        @(negedge i_clk);
        cmd_backlog.push_back(blank_cmd(rrc_pkg::MODE_CLEAR));
        cmd_backlog.push_back(read_cmd(0, 255));
        cmd_backlog.push_back(read_cmd(1, 0));
        drain_backlog();

        // random phases on small canvases, one per idling style;
        // the first also carries the long receiver hold-off
        for (p = 0; p < 4; p++) begin
            w = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 24));
            h = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 24));
            set_canvas(w, h, 8'($urandom));
            cw = (w == 0) ? 1 : int'(w);
            ch = (h == 0) ? 1 : int'(h);
            @(negedge i_clk);
            idle_mode = phase_idle[p];
            if (p == 0)
                pressure_req = 1'b1;
            for (n = 0; n < 19; n++)
                cmd_backlog.push_back(random_command(cw, ch));
            drain_backlog();
        end

        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
